@@ design/fspt_pkg.sv @@
// Shared package of the flywheel shot phase tracker.
// Holds widths, configuration register indexes, reset values and the structs passed
// between modules. No dependencies.
package fspt_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int THROTTLE_W      = 17;
	localparam int TARGET_W        = 13;
	localparam int PHASE_W         = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_INDEX_W     = 3;
	localparam int WINDOW_W        = 16;
	localparam int LIMIT_W         = 15;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CHANGE_WINDOW  = 3'd0,
		REG_SHOT_RISE      = 3'd1,
		REG_REBOUND_RISE   = 3'd2,
		REG_SETTLE_BAND    = 3'd3,
		REG_DECEL_VEL_BAND = 3'd4,
		REG_DECEL_ERR_BAND = 3'd5
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic [WINDOW_W-1:0] RST_CHANGE_WINDOW  = 16'd25;
	localparam logic [LIMIT_W-1:0]  RST_SHOT_RISE      = 15'd50;
	localparam logic [LIMIT_W-1:0]  RST_REBOUND_RISE   = 15'd20;
	localparam logic [LIMIT_W-1:0]  RST_SETTLE_BAND    = 15'd1;
	localparam logic [LIMIT_W-1:0]  RST_DECEL_VEL_BAND = 15'd10;
	localparam logic [LIMIT_W-1:0]  RST_DECEL_ERR_BAND = 15'd5;

	typedef struct packed {
		logic [WINDOW_W-1:0] change_window_ticks;
		logic [LIMIT_W-1:0]  shot_rise_limit;
		logic [LIMIT_W-1:0]  rebound_rise_limit;
		logic [LIMIT_W-1:0]  settle_band;
		logic [LIMIT_W-1:0]  decel_velocity_band;
		logic [LIMIT_W-1:0]  decel_error_band;
	} cfg_t;

	// Phase tracker result for one item.
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               stop_pulse;
		logic               reinit_pulse;
		logic               derivative_on;
	} track_res_t;

endpackage

@@ design/flywheel_shot_phase_tracker.sv @@
// Flywheel shot phase tracker, top level. Depends on fspt_pkg, fspt_speed_map
// and fspt_phase_tracker.
// Each item passes three stages: input register, stage two, output register.
// Throughput: one item per cycle, one in each stage, unless out_stall holds it.
// Reset: arst_n clears the phase state, previous samples, window timer and valid
// bits, and loads the configuration registers with their default values.
module flywheel_shot_phase_tracker #(
	parameter int SAMPLE_BITS = fspt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_wr_en,
	input  logic [fspt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fspt_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fspt_pkg::THROTTLE_W-1:0]     throttle_level,
	input  logic [SAMPLE_BITS-1:0]              setpoint_readback,
	input  logic signed [SAMPLE_BITS-1:0]       measured_velocity,
	input  logic signed [SAMPLE_BITS-1:0]       loop_error,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fspt_pkg::TARGET_W-1:0]       target_speed,
	output logic [fspt_pkg::PHASE_W-1:0]        phase,
	output logic                                stop_pulse,
	output logic                                reinit_pulse,
	output logic                                derivative_on
);

	fspt_pkg::cfg_t                     cfg_q;
	logic [fspt_pkg::THROTTLE_W-1:0]    th_s1;
	logic [SAMPLE_BITS-1:0]             sp_s1;
	logic signed [SAMPLE_BITS-1:0]      vel_s1;
	logic signed [SAMPLE_BITS-1:0]      err_s1;
	logic                               valid_s1;
	logic                               valid_s2;
	logic                               out_valid_q;
	logic                               out_ready;
	logic                               ready_s2;
	logic                               ready_s1;
	logic                               adv_s1;
	logic                               adv_s2;
	logic                               accept;
	logic [fspt_pkg::TARGET_W-1:0]      target_s2;
	fspt_pkg::track_res_t               res_s2;

	// Configuration registers. Writes must come only while the block is idle, so
	// that no item sees a register change in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.change_window_ticks <= fspt_pkg::RST_CHANGE_WINDOW;
			cfg_q.shot_rise_limit     <= fspt_pkg::RST_SHOT_RISE;
			cfg_q.rebound_rise_limit  <= fspt_pkg::RST_REBOUND_RISE;
			cfg_q.settle_band         <= fspt_pkg::RST_SETTLE_BAND;
			cfg_q.decel_velocity_band <= fspt_pkg::RST_DECEL_VEL_BAND;
			cfg_q.decel_error_band    <= fspt_pkg::RST_DECEL_ERR_BAND;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fspt_pkg::REG_CHANGE_WINDOW:  cfg_q.change_window_ticks <= cfg_data;
				fspt_pkg::REG_SHOT_RISE:      cfg_q.shot_rise_limit     <= cfg_data[14:0];
				fspt_pkg::REG_REBOUND_RISE:   cfg_q.rebound_rise_limit  <= cfg_data[14:0];
				fspt_pkg::REG_SETTLE_BAND:    cfg_q.settle_band         <= cfg_data[14:0];
				fspt_pkg::REG_DECEL_VEL_BAND: cfg_q.decel_velocity_band <= cfg_data[14:0];
				fspt_pkg::REG_DECEL_ERR_BAND: cfg_q.decel_error_band    <= cfg_data[14:0];
				default: begin
					// Indexes past the last register are ignored.
				end
			endcase
		end
	end

	// Each stage moves forward when the stage after it is empty or emptying.
	// A finished result waiting in the output register does not block the
	// earlier stages while they still have room.
	always_comb begin
		out_ready = !out_valid_q || !out_stall;
		adv_s2    = valid_s2 && out_ready;
		ready_s2  = !valid_s2 || out_ready;
		adv_s1    = valid_s1 && ready_s2;
		ready_s1  = !valid_s1 || ready_s2;
		accept    = in_valid && ready_s1;
		in_stall  = !ready_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			th_s1  <= throttle_level;
			sp_s1  <= setpoint_readback;
			vel_s1 <= measured_velocity;
			err_s1 <= loop_error;
		end
	end

	// Target speed map; its partial result sits in stage two beside the
	// tracker result.
	fspt_speed_map u_speed_map (
		.clk         (clk),
		.load        (adv_s1),
		.throttle_s1 (th_s1),
		.target      (target_s2)
	);

	// Phase tracking; its state advances exactly once per item, as the item
	// leaves the input register.
	fspt_phase_tracker #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_phase_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv_s1),
		.throttle_zero (th_s1 == '0),
		.setpoint      (sp_s1),
		.velocity      (vel_s1),
		.error         (err_s1),
		.cfg           (cfg_q),
		.res_s2        (res_s2)
	);

	// Output register; it holds while the result channel is stalled.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			target_speed  <= target_s2;
			phase         <= res_s2.phase;
			stop_pulse    <= res_s2.stop_pulse;
			reinit_pulse  <= res_s2.reinit_pulse;
			derivative_on <= res_s2.derivative_on;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/fspt_speed_map.sv @@
// Throttle to target speed map of the flywheel shot phase tracker.
// Front half registers a partial result in stage two, back half finishes the
// division by nine for the upper segment. Depends on fspt_pkg.
module fspt_speed_map (
	input  logic                               clk,
	input  logic                               load,
	input  logic [fspt_pkg::THROTTLE_W-1:0]    throttle_s1,
	output logic [fspt_pkg::TARGET_W-1:0]      target
);

	localparam logic [fspt_pkg::THROTTLE_W-1:0] THROTTLE_FULL = 17'd65536;
	localparam logic [fspt_pkg::THROTTLE_W-1:0] LO_LIMIT      = 17'd6554;
	localparam logic [31:0] LO_GAIN    = 32'd31900;
	localparam logic [31:0] LO_ROUND   = 32'd32768;
	localparam logic [12:0] LO_BASE    = 13'd10;
	localparam logic [25:0] HI_GAIN    = 26'd625;
	localparam logic [25:0] HI_OFFSET  = 26'd4077568;
	localparam logic [29:0] RECIP_NINE = 30'd58255;
	localparam logic [12:0] HI_BASE    = 13'd3200;

	logic [fspt_pkg::THROTTLE_W-1:0] th_sat;
	logic [31:0] lo_prod;
	logic [12:0] lo_target;
	logic [25:0] hi_num;
	logic        lo_sel;
	logic [13:0] part;
	logic        lo_sel_s2;
	logic [13:0] part_s2;
	logic [29:0] quot_prod;

	// The upper segment is 3200 + floor((625*th - 4077568) / 36864); the
	// division by 4096 is a shift here, the division by nine comes next stage.
	always_comb begin
		th_sat    = (throttle_s1 > THROTTLE_FULL) ? THROTTLE_FULL : throttle_s1;
		lo_sel    = th_sat < LO_LIMIT;
		lo_prod   = 32'(th_sat) * LO_GAIN + LO_ROUND;
		lo_target = 13'(lo_prod >> 16) + LO_BASE;
		hi_num    = 26'(th_sat) * HI_GAIN - HI_OFFSET;
		part      = lo_sel ? {1'b0, lo_target} : hi_num[25:12];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lo_sel_s2 <= lo_sel;
			part_s2   <= part;
		end
	end

	// The partial value stays below 9005, where multiplying by 58255 and
	// dropping 19 bits divides by nine exactly.
	always_comb begin
		quot_prod = 30'(part_s2) * RECIP_NINE;
		target    = lo_sel_s2 ? part_s2[12:0] : HI_BASE + 13'(quot_prod >> 19);
	end

endmodule

@@ design/fspt_phase_tracker.sv @@
// Phase state machine of the flywheel shot phase tracker: previous samples,
// setpoint change window, derivative select. Depends on fspt_pkg.
module fspt_phase_tracker #(
	parameter int SAMPLE_BITS = fspt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          throttle_zero,
	input  logic        [SAMPLE_BITS-1:0] setpoint,
	input  logic signed [SAMPLE_BITS-1:0] velocity,
	input  logic signed [SAMPLE_BITS-1:0] error,
	input  fspt_pkg::cfg_t                cfg,
	output fspt_pkg::track_res_t          res_s2
);

	// Compare width holds a sample difference and any limit with a sign bit.
	localparam int CW = (SAMPLE_BITS + 1 > fspt_pkg::LIMIT_W) ? SAMPLE_BITS + 2
		: fspt_pkg::LIMIT_W + 1;

	typedef enum logic [fspt_pkg::PHASE_W-1:0] {
		PH_OFF    = 3'd0,
		PH_INIT   = 3'd1,
		PH_SHOOT  = 3'd2,
		PH_BANG   = 3'd3,
		PH_STEADY = 3'd4
	} phase_t;

	phase_t                          phase_q;
	phase_t                          phase_a;
	phase_t                          phase_n;
	logic        [SAMPLE_BITS-1:0]   last_sp_q;
	logic signed [SAMPLE_BITS-1:0]   last_vel_q;
	logic signed [SAMPLE_BITS-1:0]   last_err_q;
	logic [fspt_pkg::WINDOW_W-1:0]   window_q;
	logic [fspt_pkg::WINDOW_W-1:0]   window_cur;
	logic [fspt_pkg::WINDOW_W-1:0]   window_n;
	logic                            flag_q;
	logic                            flag_a;
	logic                            flag_n;
	logic                            reinit;
	logic                            recent;
	logic signed [CW-1:0]            rise;
	logic signed [CW-1:0]            derr;
	logic signed [CW-1:0]            dvel;
	logic signed [CW-1:0]            dvel_abs;
	logic signed [CW-1:0]            shot_lim;
	logic signed [CW-1:0]            rebound_lim;
	logic signed [CW-1:0]            settle_lim;
	logic signed [CW-1:0]            dvel_lim;
	logic signed [CW-1:0]            derr_lim;

	always_comb begin
		rise        = CW'(error) - CW'(last_err_q);
		derr        = rise[CW-1] ? -rise : rise;
		dvel        = CW'(last_vel_q) - CW'(velocity);
		dvel_abs    = dvel[CW-1] ? -dvel : dvel;
		shot_lim    = CW'(cfg.shot_rise_limit);
		rebound_lim = CW'(cfg.rebound_rise_limit);
		settle_lim  = CW'(cfg.settle_band);
		dvel_lim    = CW'(cfg.decel_velocity_band);
		derr_lim    = CW'(cfg.decel_error_band);

		// A setpoint change restarts the suppression window at one.
		window_cur = (setpoint != last_sp_q) ? 16'd1 : window_q;
		recent     = (window_cur != '0) && (window_cur <= cfg.change_window_ticks);

		// Zero throttle forces the off phase first; leaving bang-bang that way
		// still sets the derivative select.
		phase_a = throttle_zero ? PH_OFF : phase_q;
		flag_a  = (throttle_zero && phase_q == PH_BANG) ? 1'b1 : flag_q;
		phase_n = phase_a;
		flag_n  = flag_a;
		reinit  = 1'b0;

		unique case (phase_a)
			PH_OFF: begin
				if (!throttle_zero) begin
					phase_n = PH_INIT;
					flag_n  = 1'b0;
					reinit  = 1'b1;
				end
			end
			PH_INIT: begin
				priority if (derr <= settle_lim) begin
					phase_n = PH_STEADY;
				end else if (rise > shot_lim && !recent) begin
					phase_n = PH_SHOOT;
				end
			end
			PH_SHOOT: begin
				if (dvel_abs < dvel_lim || derr < derr_lim) begin
					phase_n = PH_BANG;
					flag_n  = 1'b0;
				end
			end
			PH_BANG: begin
				priority if (derr <= settle_lim) begin
					phase_n = PH_STEADY;
					flag_n  = 1'b1;
				end else if (rise > rebound_lim && !recent) begin
					phase_n = PH_SHOOT;
					flag_n  = 1'b1;
				end
			end
			PH_STEADY: begin
				if (rise > shot_lim && !recent) begin
					phase_n = PH_SHOOT;
				end
			end
			default: begin
				phase_n = PH_OFF;
			end
		endcase

		// A running window stops once it reaches its length.
		if (window_cur == '0 || window_cur >= cfg.change_window_ticks) begin
			window_n = '0;
		end else begin
			window_n = window_cur + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OFF;
			last_sp_q  <= '0;
			last_vel_q <= '0;
			last_err_q <= '0;
			window_q   <= '0;
			flag_q     <= 1'b0;
			res_s2     <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			last_sp_q  <= setpoint;
			last_vel_q <= velocity;
			last_err_q <= error;
			window_q   <= window_n;
			flag_q     <= flag_n;
			res_s2.phase         <= phase_n;
			res_s2.stop_pulse    <= throttle_zero;
			res_s2.reinit_pulse  <= reinit;
			res_s2.derivative_on <= flag_n;
		end
	end

endmodule

@@ bench/fspt_track_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the flywheel shot phase tracker bench.
// Watches the register port and both channels, predicts each result and compares.
// Depends on fspt_pkg for the register indexes, reset values and widths.
module fspt_track_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fspt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fspt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [fspt_pkg::THROTTLE_W-1:0]     throttle_level,
	input  logic [15:0]                         setpoint_readback,
	input  logic signed [15:0]                  measured_velocity,
	input  logic signed [15:0]                  loop_error,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [fspt_pkg::TARGET_W-1:0]       target_speed,
	input  logic [fspt_pkg::PHASE_W-1:0]        phase,
	input  logic                                stop_pulse,
	input  logic                                reinit_pulse,
	input  logic                                derivative_on,
	output int                                  fail_count,
	output int                                  outstanding,
	output int                                  checked_count
);
	import fspt_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		PH_OFF    = 3'd0,
		PH_INIT   = 3'd1,
		PH_SHOOT  = 3'd2,
		PH_BANG   = 3'd3,
		PH_STEADY = 3'd4
	} flywheel_phase_e;

	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [PHASE_W-1:0]  phase;
		logic                stop;
		logic                reinit;
		logic                dgain;
	} track_result_t;

	cfg_t                regs;
	flywheel_phase_e     cur_phase;
	logic [15:0]         prev_sp;
	logic signed [15:0]  prev_vel;
	logic signed [15:0]  prev_err;
	logic [WINDOW_W-1:0] window_cnt;
	logic                d_gain;

	track_result_t       expected_track_q [$];
	track_result_t       want;
	track_result_t       got;
	int                  failures;
	int                  reported;
	int                  compared;

	// Phase change with its side effects on the derivative select and the re-init pulse.
	function automatic void enter_phase(input flywheel_phase_e nxt, inout logic reinit);
		if (nxt == PH_BANG)
			d_gain = 1'b0;
		else if (nxt == PH_INIT && cur_phase == PH_OFF) begin
			d_gain = 1'b0;
			reinit = 1'b1;
		end
		if (cur_phase == PH_BANG)
			d_gain = 1'b1;
		cur_phase = nxt;
	endfunction

	function automatic track_result_t predict_track(input logic [THROTTLE_W-1:0] th_in,
			input logic [15:0] sp, input logic signed [15:0] vel, input logic signed [15:0] err);
		longint        th, tgt, rise, derr, dvel;
		longint        settle_l, shot_l, rebound_l, vband_l, eband_l;
		logic          stop, reinit, off, recent;
		track_result_t r;
		settle_l  = regs.settle_band;
		shot_l    = regs.shot_rise_limit;
		rebound_l = regs.rebound_rise_limit;
		vband_l   = regs.decel_velocity_band;
		eband_l   = regs.decel_error_band;
		th = th_in;
		if (th > 65536)
			th = 65536;
		if (th * 10 < 65536)
			tgt = 10 + ((31900 * th + 32768) >> 16);
		else
			tgt = 3200 + ((1000 * (10 * th - 65536) + 294912) / 589824);
		rise = longint'(err) - longint'(prev_err);
		derr = (rise < 0) ? -rise : rise;
		dvel = longint'(prev_vel) - longint'(vel);
		if (dvel < 0)
			dvel = -dvel;
		stop = 1'b0;
		reinit = 1'b0;
		off = (th == 0);
		if (off) begin
			enter_phase(PH_OFF, reinit);
			stop = 1'b1;
		end
		if (sp != prev_sp)
			window_cnt = 1;
		recent = (window_cnt != 0) && (window_cnt <= regs.change_window_ticks);
		case (cur_phase)
			PH_OFF: begin
				if (!off)
					enter_phase(PH_INIT, reinit);
			end
			PH_INIT: begin
				if (derr <= settle_l)
					enter_phase(PH_STEADY, reinit);
				else if (rise > shot_l && !recent)
					enter_phase(PH_SHOOT, reinit);
			end
			PH_SHOOT: begin
				if (dvel < vband_l || derr < eband_l)
					enter_phase(PH_BANG, reinit);
			end
			PH_BANG: begin
				if (derr <= settle_l)
					enter_phase(PH_STEADY, reinit);
				else if (rise > rebound_l && !recent)
					enter_phase(PH_SHOOT, reinit);
			end
			PH_STEADY: begin
				if (rise > shot_l && !recent)
					enter_phase(PH_SHOOT, reinit);
			end
			default: cur_phase = PH_OFF;
		endcase
		// The window timer stops once it has run through the window, else it keeps counting.
		if (window_cnt != 0) begin
			if (window_cnt >= regs.change_window_ticks)
				window_cnt = '0;
			else
				window_cnt = window_cnt + 1'b1;
		end
		prev_sp  = sp;
		prev_vel = vel;
		prev_err = err;
		r.target = tgt[TARGET_W-1:0];
		r.phase  = cur_phase;
		r.stop   = stop;
		r.reinit = reinit;
		r.dgain  = d_gain;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.change_window_ticks = RST_CHANGE_WINDOW;
			regs.shot_rise_limit     = RST_SHOT_RISE;
			regs.rebound_rise_limit  = RST_REBOUND_RISE;
			regs.settle_band         = RST_SETTLE_BAND;
			regs.decel_velocity_band = RST_DECEL_VEL_BAND;
			regs.decel_error_band    = RST_DECEL_ERR_BAND;
			cur_phase  = PH_OFF;
			prev_sp    = '0;
			prev_vel   = '0;
			prev_err   = '0;
			window_cnt = '0;
			d_gain     = 1'b0;
			expected_track_q.delete();
			failures = 0;
			reported = 0;
			compared = 0;
			fail_count    <= 0;
			outstanding   <= 0;
			checked_count <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CHANGE_WINDOW:  regs.change_window_ticks = cfg_data;
					REG_SHOT_RISE:      regs.shot_rise_limit     = cfg_data[LIMIT_W-1:0];
					REG_REBOUND_RISE:   regs.rebound_rise_limit  = cfg_data[LIMIT_W-1:0];
					REG_SETTLE_BAND:    regs.settle_band         = cfg_data[LIMIT_W-1:0];
					REG_DECEL_VEL_BAND: regs.decel_velocity_band = cfg_data[LIMIT_W-1:0];
					REG_DECEL_ERR_BAND: regs.decel_error_band    = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_track_q.push_back(predict_track(throttle_level, setpoint_readback,
					measured_velocity, loop_error));
			if (out_valid && !out_stall) begin
				got = '{target_speed, phase, stop_pulse, reinit_pulse, derivative_on};
				compared++;
				if (expected_track_q.size() == 0) begin
					failures++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result: target %0d phase %0d stop %0b reinit %0b dgain %0b",
							got.target, got.phase, got.stop, got.reinit, got.dgain);
					end
				end else begin
					want = expected_track_q.pop_front();
					if (got != want) begin
						failures++;
						if (reported < 10) begin
							reported++;
							$display("mismatch on result %0d: expected target %0d phase %0d stop %0b reinit %0b dgain %0b",
								compared, want.target, want.phase, want.stop, want.reinit, want.dgain);
							$display("    got target %0d phase %0d stop %0b reinit %0b dgain %0b",
								got.target, got.phase, got.stop, got.reinit, got.dgain);
						end
					end
				end
			end
			fail_count    <= failures;
			outstanding   <= expected_track_q.size();
			checked_count <= compared;
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Top of the flywheel shot phase tracker bench: clock, reset, stimulus and verdict.
// Depends on fspt_pkg, the flywheel_shot_phase_tracker block and fspt_track_checker.
module tb;
	import fspt_pkg::*;

	// A write to an index past the register list must be ignored by the block.
	localparam logic [CFG_INDEX_W-1:0] UNMAPPED_REG = 3'd7;
	// Length of the forced receiver hold-off, long enough to fill all three stages.
	localparam int HOLD_CYCLES = 80;
	// The longest quiet spells of a correct run (hold-off, heavy stall stretches, sender
	// gaps, drains) stay well inside this limit, so it is ample.
	localparam int QUIET_LIMIT = 3000;

	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_EVERY_THIRD
	} rx_mode_e;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [THROTTLE_W-1:0]      throttle_level;
	logic [15:0]                setpoint_readback;
	logic signed [15:0]         measured_velocity;
	logic signed [15:0]         loop_error;
	logic                       out_valid;
	logic                       out_stall;
	logic [TARGET_W-1:0]        target_speed;
	logic [PHASE_W-1:0]         phase;
	logic                       stop_pulse;
	logic                       reinit_pulse;
	logic                       derivative_on;

	int fail_count;
	int outstanding;
	int checked_count;

	int items_sent;
	int settings_used;
	int burst_left;
	int hold_requests;

	// Running state of the synthetic flywheel that the shot sequences are built on.
	int          track_err;
	int          track_vel;
	logic [15:0] track_sp;
	// Register values in force, used only to aim the error jumps at the thresholds.
	logic [15:0] cfg_val [6];

	flywheel_shot_phase_tracker u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.throttle_level    (throttle_level),
		.setpoint_readback (setpoint_readback),
		.measured_velocity (measured_velocity),
		.loop_error        (loop_error),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.target_speed      (target_speed),
		.phase             (phase),
		.stop_pulse        (stop_pulse),
		.reinit_pulse      (reinit_pulse),
		.derivative_on     (derivative_on)
	);

	fspt_track_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.throttle_level    (throttle_level),
		.setpoint_readback (setpoint_readback),
		.measured_velocity (measured_velocity),
		.loop_error        (loop_error),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.target_speed      (target_speed),
		.phase             (phase),
		.stop_pulse        (stop_pulse),
		.reinit_pulse      (reinit_pulse),
		.derivative_on     (derivative_on),
		.fail_count        (fail_count),
		.outstanding       (outstanding),
		.checked_count     (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one item and holds it until the block takes it. The sender works in bursts:
	// when a burst runs out, valid drops for a random gap before the next item.
	task automatic send_sample(input logic [THROTTLE_W-1:0] th, input logic [15:0] sp,
			input int vel, input int err);
		in_valid <= 1'b1;
		throttle_level <= th;
		setpoint_readback <= sp;
		measured_velocity <= 16'(vel);
		loop_error <= 16'(err);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Lets every outstanding item come back, then idles before returning.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Registers change only with the block empty; the unmapped write must leave all alone.
	task automatic program_settings(input logic [15:0] window, input logic [15:0] shot,
			input logic [15:0] rebound, input logic [15:0] settle, input logic [15:0] vband,
			input logic [15:0] eband);
		drain();
		cfg_val[REG_CHANGE_WINDOW]  = window;
		cfg_val[REG_SHOT_RISE]      = shot;
		cfg_val[REG_REBOUND_RISE]   = rebound;
		cfg_val[REG_SETTLE_BAND]    = settle;
		cfg_val[REG_DECEL_VEL_BAND] = vband;
		cfg_val[REG_DECEL_ERR_BAND] = eband;
		write_reg(REG_CHANGE_WINDOW, window);
		write_reg(REG_SHOT_RISE, shot);
		write_reg(REG_REBOUND_RISE, rebound);
		write_reg(REG_SETTLE_BAND, settle);
		write_reg(REG_DECEL_VEL_BAND, vband);
		write_reg(REG_DECEL_ERR_BAND, eband);
		write_reg(UNMAPPED_REG, 16'hFFFF);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// A quiet stretch: the error wanders by at most one count, so the tracker can settle.
	task automatic settle_run();
		repeat ($urandom_range(2, 6)) begin
			track_err += int'($urandom_range(0, 2)) - 1;
			track_vel += int'($urandom_range(0, 4)) - 2;
			send_sample(throttle_level, track_sp, track_vel, track_err);
		end
	endtask

	// Most of the random items form whole shot sequences: settle, an error jump placed on
	// or just above the shot limit or far above it, a falling error with a moving velocity,
	// a period with the velocity held, sometimes a rebound, and settling again. The rest
	// are items with every field random.
	task automatic run_random(input int count);
		int                    stop_at;
		int                    shot_lim;
		int                    reb_lim;
		logic [THROTTLE_W-1:0] th;
		stop_at  = items_sent + count;
		shot_lim = cfg_val[REG_SHOT_RISE] & 16'h7FFF;
		reb_lim  = cfg_val[REG_REBOUND_RISE] & 16'h7FFF;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				th = ($urandom_range(0, 7) == 0) ? '0 : THROTTLE_W'($urandom_range(0, 131071));
				send_sample(th, 16'($urandom), $urandom, $urandom);
			end else begin
				if ($urandom_range(0, 3) == 0)
					track_sp = 16'($urandom);
				case ($urandom_range(0, 9))
					0: th = THROTTLE_W'($urandom_range(1, 6553));
					1: th = THROTTLE_W'($urandom_range(65536, 131071));
					default: th = THROTTLE_W'($urandom_range(6554, 65536));
				endcase
				track_err = int'($urandom_range(0, 4000)) - 2000;
				// Now and then the throttle drops to zero first, forcing off and re-init.
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 2))
						send_sample('0, track_sp, track_vel, track_err);
				send_sample(th, track_sp, track_vel, track_err);
				settle_run();
				case ($urandom_range(0, 2))
					0: track_err += shot_lim;
					1: track_err += shot_lim + 1;
					default: track_err += shot_lim + int'($urandom_range(2, 3000));
				endcase
				track_vel -= int'($urandom_range(0, 800));
				send_sample(th, track_sp, track_vel, track_err);
				repeat ($urandom_range(1, 5)) begin
					track_err -= int'($urandom_range(0, 600));
					track_vel += int'($urandom_range(0, 60)) - 30;
					send_sample(th, track_sp, track_vel, track_err);
				end
				track_err -= int'($urandom_range(0, 40));
				send_sample(th, track_sp, track_vel, track_err);
				if ($urandom_range(0, 4) < 2) begin
					track_err += reb_lim + int'($urandom_range(0, 2));
					send_sample(th, track_sp, track_vel, track_err);
				end
				settle_run();
			end
		end
	endtask

	// Receiver: changes between free flow, light and heavy random stalls and a fixed
	// pattern, each for a random stretch. A hold-off request stalls it for a long run.
	initial begin : result_stall
		rx_mode_e mode;
		int       left;
		int       tick;
		int       served;
		out_stall <= 1'b0;
		mode = RX_FREE;
		left = 0;
		tick = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1)
					@(posedge clk);
			end else begin
				if (left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					left = $urandom_range(10, 80);
				end
				left--;
				tick++;
				case (mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
					RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
					default:  out_stall <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// Watchdog: ends the run if neither channel moves an item for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("[flywheel_shot_phase_tracker] ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		throttle_level <= '0;
		setpoint_readback <= '0;
		measured_velocity <= '0;
		loop_error <= '0;
		cfg_val[REG_CHANGE_WINDOW]  = RST_CHANGE_WINDOW;
		cfg_val[REG_SHOT_RISE]      = RST_SHOT_RISE;
		cfg_val[REG_REBOUND_RISE]   = RST_REBOUND_RISE;
		cfg_val[REG_SETTLE_BAND]    = RST_SETTLE_BAND;
		cfg_val[REG_DECEL_VEL_BAND] = RST_DECEL_VEL_BAND;
		cfg_val[REG_DECEL_ERR_BAND] = RST_DECEL_ERR_BAND;
		items_sent = 0;
		settings_used = 1;
		burst_left = 12;
		hold_requests = 0;
		track_err = 0;
		track_vel = 0;
		track_sp = '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk under the reset settings. Zero throttle out of reset gives a stop.
		send_sample('0, 16'd0, 0, 0);
		// First nonzero throttle: off to init with the re-init pulse, smallest target.
		send_sample(17'd1, 16'd0, 0, 0);
		// Last throttle of the low range; error rise over the shot limit starts a shot.
		send_sample(17'd6553, 16'd0, 0, 100);
		// First throttle of the upper range; velocity held, so the shot decays to bang-bang.
		send_sample(17'd6554, 16'd0, 0, 100);
		// Full throttle; a rebound rise goes back to shoot and sets the derivative select.
		send_sample(17'd65536, 16'd0, 300, 130);
		// Throttle over full saturates; big velocity and error moves keep the shot going.
		send_sample(17'd65537, 16'd0, 700, 400);
		// Largest throttle code; a tiny error change ends the shot.
		send_sample(17'd131071, 16'd0, 1000, 402);
		// No error change: bang-bang settles to steady.
		send_sample(17'd40000, 16'd0, 1000, 402);
		// A rise exactly at the shot limit is not a shot, one above it is.
		send_sample(17'd40000, 16'd0, 1000, 452);
		send_sample(17'd40000, 16'd0, 1000, 503);
		// Setpoint change with the sample extremes; the window now suppresses detection.
		send_sample(17'd40000, 16'hFFFF, -32768, 32767);
		send_sample(17'd40000, 16'hFFFF, -32768, 32767);
		send_sample(17'd40000, 16'hFFFF, 32767, -32768);
		send_sample(17'd40000, 16'hFFFF, 32767, 0);
		// Throttle to zero while in bang-bang, held off for a second period.
		send_sample('0, 16'hFFFF, 0, 0);
		send_sample('0, 16'hFFFF, 0, 0);
		// Back on: re-init clears the derivative select.
		send_sample(17'd65535, 16'hFFFF, 0, 0);
		// Another setpoint change, then a rise that would be a shot but for the window.
		send_sample(17'd65535, 16'h8000, 0, 40);
		send_sample(17'd65535, 16'h8000, 0, 200);
		send_sample(17'd1, 16'h8000, -1, 199);

		// Long receiver hold-off with the sender offering without gaps, so that the block
		// fills up and has to stall its input.
		hold_requests++;
		burst_left = 40;
		run_random(110);

		// Low extremes: shortest nonzero window, all limits and bands zero.
		program_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(80);
		// High extremes: longest window and all-ones data, which the 15-bit registers trim.
		program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(70);
		// Zero window: detection is never held off. A second hold-off runs here.
		program_settings(16'd0, 16'($urandom_range(0, 300)), 16'($urandom_range(0, 150)),
			16'($urandom_range(0, 4)), 16'($urandom_range(0, 60)), 16'($urandom_range(0, 30)));
		hold_requests++;
		burst_left = 40;
		run_random(90);
		program_settings(16'($urandom_range(1, 40)), 16'($urandom_range(0, 300)),
			16'($urandom_range(0, 150)), 16'($urandom_range(0, 4)), 16'($urandom_range(0, 60)),
			16'($urandom_range(0, 30)));
		run_random(90);
		// Back to the reset values, written explicitly this time.
		program_settings(RST_CHANGE_WINDOW, 16'(RST_SHOT_RISE), 16'(RST_REBOUND_RISE),
			16'(RST_SETTLE_BAND), 16'(RST_DECEL_VEL_BAND), 16'(RST_DECEL_ERR_BAND));
		run_random(90);
		drain();

		$display("Run covered %0d samples under %0d register settings, both extremes and a",
			items_sent, settings_used);
		$display("zero window among them; %0d results compared, %0d failures.",
			checked_count, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("[flywheel_shot_phase_tracker] OK");
		else
			$display("[flywheel_shot_phase_tracker] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/fspt_pkg.sv
design/fspt_speed_map.sv
design/fspt_phase_tracker.sv
design/flywheel_shot_phase_tracker.sv
bench/fspt_track_checker.sv
bench/tb.sv
